// ===== hw/rtl/ill_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ill_pkg
// Shared types and codes of the indexed linked-list engine: field widths,
// operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package ill_pkg;

  localparam int OP_W  = 3;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_W = 9;

  localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
  localparam logic [OP_W-1:0] OP_POP       = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ      = 3'd4;
  localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_TAKE,
    S_TAKE_W,
    S_APP_LINK,
    S_WALK_START,
    S_WALK,
    S_UL_HEAD,
    S_UL_HEAD_W,
    S_UL_READ,
    S_UL_NEXT,
    S_UL_LINK,
    S_UL_GIVE,
    S_INS_HEAD,
    S_INS_READ,
    S_INS_LINK,
    S_INS_PREV,
    S_RD,
    S_RD_W,
    S_WR,
    S_FIN
  } state_t;

endpackage

// ===== hw/rtl/ill_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ill_req_if
// Request channel: one operation word with position and value.
// ----------------------------------------------------------------------------
interface ill_req_if;
  logic                                valid;
  logic                                ready;
  logic [ill_pkg::OP_W-1:0]            op;
  logic [ill_pkg::POS_W-1:0]           position;
  logic signed [ill_pkg::VAL_W-1:0]    value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink (input valid, input op, input position, input value, output ready);
endinterface

// ===== hw/rtl/ill_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ill_rsp_if
// Response channel: read value, status and element count.
// ----------------------------------------------------------------------------
interface ill_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ill_pkg::VAL_W-1:0]    read_value;
  logic [ill_pkg::ST_W-1:0]            status;
  logic [ill_pkg::CNT_W-1:0]           count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink (input valid, input read_value, input status, input count, output ready);
endinterface

// ===== hw/rtl/indexed_linked_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_linked_list_engine
// Bounded list of signed 32-bit words kept as a singly linked chain in a node
// RAM, with a free chain for allocation; one small sequencer drives the link
// and element RAM ports.
//
//   channel  dir  payload                         handshake
//   req      in   op[2:0] position[7:0] value[31:0] valid/ready
//   rsp      out  read_value[31:0] status[1:0] count[8:0] valid/ready
//
// The time from acceptance to response grows with the position for read,
// overwrite, remove and insert, and with the count for a pop of a longer
// list; the chain walk, one link RAM read per cycle, sets it.
// After reset the link RAM is initialized while req.ready is low. One word
// is processed at a time; req.ready is high only while idle, from the cycle
// after the response is loaded. A finished word waits in the output
// register; the next request is taken while it waits.
// ----------------------------------------------------------------------------
module indexed_linked_list_engine #(
  parameter int CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst,
  ill_req_if.sink    req,
  ill_rsp_if.source  rsp
);

  localparam int NW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > ill_pkg::POS_W) ? CW : ill_pkg::POS_W;

  ill_pkg::state_t state, state_next;

  logic [ill_pkg::OP_W-1:0]  op_r;
  logic [ill_pkg::POS_W-1:0] pos_r;
  logic [ill_pkg::VAL_W-1:0] val_r;
  logic [NW-1:0] first, first_next;
  logic [NW-1:0] last, last_next;
  logic [NW-1:0] free_head, free_head_next;
  logic [NW-1:0] cur, cur_next;
  logic [NW-1:0] node_n, node_n_next;
  logic [NW-1:0] rem, rem_next;
  logic [NW-1:0] clr_idx, clr_idx_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] steps, steps_next;
  logic [ill_pkg::ST_W-1:0]  status_r, status_next;
  logic [ill_pkg::VAL_W-1:0] rd_r, rd_next;

  logic                      out_valid;
  logic [ill_pkg::VAL_W-1:0] out_value;
  logic [ill_pkg::ST_W-1:0]  out_status;
  logic [ill_pkg::CNT_W-1:0] out_count;
  logic                      out_load;

  logic          link_we;
  logic [NW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
  logic          elem_we;
  logic [NW-1:0] elem_waddr, elem_raddr;
  logic [ill_pkg::VAL_W-1:0] elem_wdata, elem_rdata;

  logic [PW-1:0] pos_x, cnt_x;
  logic          is_full, is_empty;
  ill_pkg::state_t walk_done;

  ill_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  ill_ram #(.WIDTH(ill_pkg::VAL_W), .DEPTH(CAPACITY)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  assign req.ready      = (state == ill_pkg::S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.status     = out_status;
  assign rsp.count      = out_count;

  assign pos_x    = PW'(pos_r);
  assign cnt_x    = PW'(count);
  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);

  always_comb begin
    case (op_r)
      ill_pkg::OP_POP, ill_pkg::OP_REMOVE: walk_done = ill_pkg::S_UL_READ;
      ill_pkg::OP_INSERT:                  walk_done = ill_pkg::S_INS_READ;
      ill_pkg::OP_READ:                    walk_done = ill_pkg::S_RD;
      ill_pkg::OP_OVERWRITE:               walk_done = ill_pkg::S_WR;
      default:                             walk_done = ill_pkg::S_FIN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ill_pkg::S_CLEAR;
      clr_idx   <= '0;
      first     <= '0;
      last      <= '0;
      free_head <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      first     <= first_next;
      last      <= last_next;
      free_head <= free_head_next;
      count     <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    node_n   <= node_n_next;
    rem      <= rem_next;
    steps    <= steps_next;
    status_r <= status_next;
    rd_r     <= rd_next;
    if (req.valid && req.ready) begin
      op_r  <= req.op;
      pos_r <= req.position;
      val_r <= req.value;
    end
    if (out_load) begin
      out_value  <= rd_r;
      out_status <= status_r;
      out_count  <= ill_pkg::CNT_W'(count);
    end
  end

  always_comb begin
    state_next     = state;
    clr_idx_next   = clr_idx;
    first_next     = first;
    last_next      = last;
    free_head_next = free_head;
    count_next     = count;
    cur_next       = cur;
    node_n_next    = node_n;
    rem_next       = rem;
    steps_next     = steps;
    status_next    = status_r;
    rd_next        = rd_r;
    out_load       = 1'b0;
    link_we        = 1'b0;
    link_waddr     = cur;
    link_wdata     = link_rdata;
    link_raddr     = cur;
    elem_we        = 1'b0;
    elem_waddr     = cur;
    elem_wdata     = val_r;
    elem_raddr     = cur;

    case (state)
      ill_pkg::S_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_idx;
        if (clr_idx == NW'(CAPACITY - 1)) begin
          link_wdata = '0;
          state_next = ill_pkg::S_IDLE;
        end else begin
          link_wdata   = clr_idx + NW'(1);
          clr_idx_next = clr_idx + NW'(1);
        end
      end

      ill_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = ill_pkg::S_DECODE;
        end
      end

      ill_pkg::S_DECODE: begin
        status_next = ill_pkg::ST_OK;
        rd_next     = '0;
        cur_next    = first;
        state_next  = ill_pkg::S_FIN;
        case (op_r)
          ill_pkg::OP_APPEND: begin
            if (is_full) status_next = ill_pkg::ST_FULL;
            else state_next = ill_pkg::S_TAKE;
          end
          ill_pkg::OP_POP: begin
            if (is_empty) begin
              status_next = ill_pkg::ST_EMPTY;
            end else if (count == CW'(1)) begin
              rem_next   = first;
              state_next = ill_pkg::S_UL_HEAD;
            end else begin
              steps_next = count - CW'(2);
              state_next = ill_pkg::S_WALK_START;
            end
          end
          ill_pkg::OP_REMOVE: begin
            if (is_empty) begin
              status_next = ill_pkg::ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
              status_next = ill_pkg::ST_RANGE;
            end else if (pos_r == '0) begin
              rem_next   = first;
              state_next = ill_pkg::S_UL_HEAD;
            end else begin
              steps_next = CW'(pos_x - PW'(1));
              state_next = ill_pkg::S_WALK_START;
            end
          end
          ill_pkg::OP_INSERT: begin
            if (pos_x > cnt_x) begin
              status_next = ill_pkg::ST_RANGE;
            end else if (is_full) begin
              status_next = ill_pkg::ST_FULL;
            end else begin
              steps_next = CW'(pos_x - PW'(1));
              state_next = ill_pkg::S_TAKE;
            end
          end
          ill_pkg::OP_READ, ill_pkg::OP_OVERWRITE: begin
            if (is_empty) begin
              status_next = ill_pkg::ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
              status_next = ill_pkg::ST_RANGE;
            end else begin
              steps_next = CW'(pos_x);
              state_next = ill_pkg::S_WALK_START;
            end
          end
          default: state_next = ill_pkg::S_FIN;
        endcase
      end

      ill_pkg::S_TAKE: begin
        link_raddr  = free_head;
        elem_we     = 1'b1;
        elem_waddr  = free_head;
        node_n_next = free_head;
        state_next  = ill_pkg::S_TAKE_W;
      end

      ill_pkg::S_TAKE_W: begin
        free_head_next = link_rdata;
        if (op_r == ill_pkg::OP_APPEND) begin
          state_next = ill_pkg::S_APP_LINK;
        end else if (pos_r == '0) begin
          state_next = ill_pkg::S_INS_HEAD;
        end else begin
          state_next = ill_pkg::S_WALK_START;
        end
      end

      ill_pkg::S_APP_LINK: begin
        if (is_empty) begin
          first_next = node_n;
        end else begin
          link_we    = 1'b1;
          link_waddr = last;
          link_wdata = node_n;
        end
        last_next  = node_n;
        count_next = count + CW'(1);
        state_next = ill_pkg::S_FIN;
      end

      ill_pkg::S_WALK_START: begin
        if (steps == '0) begin
          state_next = walk_done;
        end else begin
          link_raddr = cur;
          steps_next = steps - CW'(1);
          state_next = ill_pkg::S_WALK;
        end
      end

      ill_pkg::S_WALK: begin
        if (steps == '0) begin
          cur_next   = link_rdata;
          state_next = walk_done;
        end else begin
          link_raddr = link_rdata;
          steps_next = steps - CW'(1);
        end
      end

      ill_pkg::S_UL_HEAD: begin
        link_raddr = rem;
        state_next = ill_pkg::S_UL_HEAD_W;
      end

      ill_pkg::S_UL_HEAD_W: begin
        first_next = link_rdata;
        state_next = ill_pkg::S_UL_GIVE;
      end

      ill_pkg::S_UL_READ: begin
        link_raddr = cur;
        state_next = ill_pkg::S_UL_NEXT;
      end

      ill_pkg::S_UL_NEXT: begin
        rem_next   = link_rdata;
        link_raddr = link_rdata;
        state_next = ill_pkg::S_UL_LINK;
      end

      ill_pkg::S_UL_LINK: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = link_rdata;
        if (rem == last) begin
          last_next = cur;
        end
        state_next = ill_pkg::S_UL_GIVE;
      end

      ill_pkg::S_UL_GIVE: begin
        link_we        = 1'b1;
        link_waddr     = rem;
        link_wdata     = free_head;
        free_head_next = rem;
        count_next     = count - CW'(1);
        state_next     = ill_pkg::S_FIN;
      end

      ill_pkg::S_INS_HEAD: begin
        link_we    = 1'b1;
        link_waddr = node_n;
        link_wdata = first;
        first_next = node_n;
        if (is_empty) begin
          last_next = node_n;
        end
        count_next = count + CW'(1);
        state_next = ill_pkg::S_FIN;
      end

      ill_pkg::S_INS_READ: begin
        link_raddr = cur;
        state_next = ill_pkg::S_INS_LINK;
      end

      ill_pkg::S_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = node_n;
        link_wdata = link_rdata;
        state_next = ill_pkg::S_INS_PREV;
      end

      ill_pkg::S_INS_PREV: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = node_n;
        if (cur == last) begin
          last_next = node_n;
        end
        count_next = count + CW'(1);
        state_next = ill_pkg::S_FIN;
      end

      ill_pkg::S_RD: begin
        elem_raddr = cur;
        state_next = ill_pkg::S_RD_W;
      end

      ill_pkg::S_RD_W: begin
        rd_next    = elem_rdata;
        state_next = ill_pkg::S_FIN;
      end

      ill_pkg::S_WR: begin
        elem_we    = 1'b1;
        elem_waddr = cur;
        state_next = ill_pkg::S_FIN;
      end

      ill_pkg::S_FIN: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ill_pkg::S_IDLE;
        end
      end

      default: state_next = ill_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == $past(count) + CW'(1) || count + CW'(1) == $past(count)))
    else $error("element count moved by more than one");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == ill_pkg::S_FIN && status_r == ill_pkg::ST_FULL) |-> is_full)
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (state == ill_pkg::S_FIN && status_r == ill_pkg::ST_EMPTY) |-> is_empty)
    else $error("empty status on a non-empty list");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ill_pkg::S_WALK) |-> (steps < count))
    else $error("chain walk runs past the list");
`endif

endmodule

// ===== hw/rtl/ill_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ill_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ill_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
